### rtl/apq_pkg.sv
`timescale 1ns / 1ps
package apq_pkg;

  localparam int DEPTH_DEF  = 32;
  localparam int VALUE_W    = 16;
  localparam int PRIO_W     = 8;
  localparam int CFG_W      = 6;
  localparam int COUNT_W    = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 6'd32;

  // register word indexes
  localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_SORT    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  localparam int ENTRY_W = VALUE_W + PRIO_W;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_ADD,
    DP_CLEAR,
    DP_I_ZERO,
    DP_SCAN_START,
    DP_SCAN,
    DP_SHIFT_START,
    DP_SHIFT_RD,
    DP_SHIFT_WR,
    DP_X_DONE,
    DP_SWAP_A,
    DP_SWAP_B,
    DP_NEXT_I,
    DP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_OUTER,
    S_SCAN,
    S_SHIFT_START,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SWAP_A,
    S_SWAP_B,
    S_FINISH
  } state_t;

  typedef struct packed {
    cmd_t cmd;
    logic cnt_zero;
    logic i_last;
    logic j_end;
    logic pos_is_i;
  } status_t;

endpackage

### rtl/apq_ram.sv
`timescale 1ns / 1ps
module apq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/apq_ctrl.sv
`timescale 1ns / 1ps
module apq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  apq_pkg::status_t status,
  output apq_pkg::dp_op_t  op
);
  import apq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = DP_NOP;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = DP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.cmd)
          CMD_ADD: begin
            op        = DP_ADD;
            state_nxt = S_FINISH;
          end
          CMD_CLEAR: begin
            op        = DP_CLEAR;
            state_nxt = S_FINISH;
          end
          default: begin
            op        = DP_I_ZERO;
            state_nxt = S_OUTER;
          end
        endcase
      end
      S_OUTER: begin
        if ((status.cmd == CMD_EXTRACT) ? status.cnt_zero : status.i_last) begin
          state_nxt = S_FINISH;
        end else begin
          op        = DP_SCAN_START;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        op = DP_SCAN;
        if (status.j_end) begin
          state_nxt = (status.cmd == CMD_EXTRACT) ? S_SHIFT_START : S_SWAP_A;
        end
      end
      S_SHIFT_START: begin
        op        = DP_SHIFT_START;
        state_nxt = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (status.j_end) begin
          op        = DP_X_DONE;
          state_nxt = S_FINISH;
        end else begin
          op        = DP_SHIFT_RD;
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        op        = DP_SHIFT_WR;
        state_nxt = S_SHIFT_RD;
      end
      S_SWAP_A: begin
        if (status.pos_is_i) begin
          op        = DP_NEXT_I;
          state_nxt = S_OUTER;
        end else begin
          op        = DP_SWAP_A;
          state_nxt = S_SWAP_B;
        end
      end
      S_SWAP_B: begin
        op        = DP_SWAP_B;
        state_nxt = S_OUTER;
      end
      S_FINISH: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          op            = DP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/apq_dp.sv
`timescale 1ns / 1ps
module apq_dp #(
  parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  apq_pkg::dp_op_t              op,
  input  logic [1:0]                   in_cmd,
  input  logic [apq_pkg::VALUE_W-1:0]  in_item_value,
  input  logic [apq_pkg::PRIO_W-1:0]   in_item_priority,
  input  logic [apq_pkg::CFG_W-1:0]    max_entries,
  output apq_pkg::status_t             status,
  output logic [apq_pkg::VALUE_W-1:0]  out_value,
  output logic                         out_found,
  output logic                         out_dropped,
  output logic [apq_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                         out_is_empty,
  output logic                         out_is_full
);
  import apq_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  cmd_t               cmd_r, cmd_nxt;
  entry_t             in_ent_r, in_ent_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      rd_addr_r;
  entry_t             best_r, best_nxt;
  entry_t             ent_i_r, ent_i_nxt;
  logic               first_r, first_nxt;
  logic [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic               res_found_r, res_found_nxt;
  logic               res_dropped_r, res_dropped_nxt;

  logic [VALUE_W-1:0] out_value_r;
  logic               out_found_r, out_dropped_r, out_empty_r, out_full_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] rdata_bits;

  logic [CMPW-1:0]    cnt_ext, max_ext, limit;
  logic               full;
  logic               key_gt, take;
  logic [CW:0]        i_plus1;

  apq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata_bits)
  );

  assign ram_rdata = entry_t'(rdata_bits);

  // capacity is the configured limit clamped to the array depth
  assign cnt_ext = CMPW'(cnt_r);
  assign max_ext = CMPW'(max_entries);
  assign limit   = (max_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : max_ext;
  assign full    = cnt_ext >= limit;

  assign key_gt  = (cmd_r == CMD_EXTRACT) ? (ram_rdata.prio > best_r.prio)
                                          : (ram_rdata.value > best_r.value);
  assign take    = first_r || key_gt;
  assign i_plus1 = {1'b0, i_r} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    cmd_nxt         = cmd_r;
    in_ent_nxt      = in_ent_r;
    cnt_nxt         = cnt_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    pos_nxt         = pos_r;
    best_nxt        = best_r;
    ent_i_nxt       = ent_i_r;
    first_nxt       = first_r;
    res_value_nxt   = res_value_r;
    res_found_nxt   = res_found_r;
    res_dropped_nxt = res_dropped_r;
    ram_we          = 1'b0;
    ram_waddr       = cnt_r[AW-1:0];
    ram_wdata       = in_ent_r;
    ram_raddr       = j_r[AW-1:0];
    case (op)
      DP_LATCH: begin
        cmd_nxt         = cmd_t'(in_cmd);
        in_ent_nxt      = '{value: in_item_value, prio: in_item_priority};
        res_value_nxt   = '0;
        res_found_nxt   = 1'b0;
        res_dropped_nxt = 1'b0;
      end
      DP_ADD: begin
        if (full) begin
          res_dropped_nxt = 1'b1;
        end else begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      DP_CLEAR: begin
        cnt_nxt = '0;
      end
      DP_I_ZERO: begin
        i_nxt = '0;
      end
      DP_SCAN_START: begin
        ram_raddr = i_r[AW-1:0];
        j_nxt     = i_plus1[CW-1:0];
        first_nxt = 1'b1;
      end
      DP_SCAN: begin
        // data in hand came from rd_addr_r, next read is issued at j
        if (take) begin
          best_nxt = ram_rdata;
          pos_nxt  = rd_addr_r;
        end
        if (first_r) begin
          ent_i_nxt = ram_rdata;
        end
        first_nxt = 1'b0;
        if (j_r != cnt_r) begin
          j_nxt = j_r + CW'(1);
        end
      end
      DP_SHIFT_START: begin
        j_nxt = CW'(pos_r) + CW'(1);
      end
      DP_SHIFT_RD: begin
        ram_raddr = j_r[AW-1:0];
      end
      DP_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_r - CW'(1));
        ram_wdata = ram_rdata;
        j_nxt     = j_r + CW'(1);
      end
      DP_X_DONE: begin
        cnt_nxt       = cnt_r - CW'(1);
        res_found_nxt = 1'b1;
        res_value_nxt = best_r.value;
      end
      DP_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = best_r;
      end
      DP_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = ent_i_r;
        i_nxt     = i_plus1[CW-1:0];
      end
      DP_NEXT_I: begin
        i_nxt = i_plus1[CW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    in_ent_r      <= in_ent_nxt;
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    pos_r         <= pos_nxt;
    rd_addr_r     <= ram_raddr;
    best_r        <= best_nxt;
    ent_i_r       <= ent_i_nxt;
    first_r       <= first_nxt;
    res_value_r   <= res_value_nxt;
    res_found_r   <= res_found_nxt;
    res_dropped_r <= res_dropped_nxt;
    if (op == DP_FINISH) begin
      out_value_r   <= res_value_r;
      out_found_r   <= res_found_r;
      out_dropped_r <= res_dropped_r;
      out_count_r   <= cnt_ext[COUNT_W-1:0];
      out_empty_r   <= (cnt_r == '0);
      out_full_r    <= full;
    end
  end

  assign status.cmd      = cmd_r;
  assign status.cnt_zero = (cnt_r == '0);
  assign status.i_last   = i_plus1 >= {1'b0, cnt_r};
  assign status.j_end    = (j_r == cnt_r);
  assign status.pos_is_i = (pos_r == i_r[AW-1:0]);

  assign out_value       = out_value_r;
  assign out_found       = out_found_r;
  assign out_dropped     = out_dropped_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

endmodule

### rtl/array_priority_queue.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       in_cmd, in_item_value, in_item_priority
// out       output     out_valid / out_ready     out_value, out_found, out_dropped,
//                                                out_entry_count, out_is_empty, out_is_full
// cfg       input      apb psel/penable, pready  cfg_paddr, cfg_pwdata, cfg_prdata
//
// one item at a time; n entries held, memory with one read and one write port per cycle.
// add and clear go from dispatch straight to the result; extract and sort run a scan loop
// over the entry memory, followed by a shift (extract) or a swap (sort).
// synchronous active-low reset empties the queue and sets max_entries to 32; no clearing pass.
// a new item is taken while the previous result waits; a stalled result holds the block
// at its final step.
module array_priority_queue #(
  parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_cmd,
  input  logic [apq_pkg::VALUE_W-1:0]     in_item_value,
  input  logic [apq_pkg::PRIO_W-1:0]      in_item_priority,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [apq_pkg::VALUE_W-1:0]     out_value,
  output logic                            out_found,
  output logic                            out_dropped,
  output logic [apq_pkg::COUNT_W-1:0]     out_entry_count,
  output logic                            out_is_empty,
  output logic                            out_is_full,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [apq_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [apq_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [apq_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import apq_pkg::*;

  logic [CFG_W-1:0] max_entries_r, max_entries_nxt;
  logic             cfg_wr;
  logic [0:0]       cfg_word;
  dp_op_t           op;
  status_t          status;

  assign cfg_pready = 1'b1;
  assign cfg_word   = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    max_entries_nxt = max_entries_r;
    if (cfg_wr && (cfg_word == REG_MAX_ENTRIES)) begin
      max_entries_nxt = cfg_pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
    end else begin
      max_entries_r <= max_entries_nxt;
    end
  end

  assign cfg_prdata = (cfg_word == REG_MAX_ENTRIES) ?
                      {{(CFG_DATA_W-CFG_W){1'b0}}, max_entries_r} : '0;

  apq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  apq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_cmd           (in_cmd),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .max_entries      (max_entries_r),
    .status           (status),
    .out_value        (out_value),
    .out_found        (out_found),
    .out_dropped      (out_dropped),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

endmodule
